[hdl/wsfp_pkg.sv]
// Shared types, constants and helpers for the WebSocket frame parser.
package wsfp_pkg;

  localparam int unsigned LenBits  = 64;
  localparam int unsigned PlenW    = 64;
  localparam int unsigned CntW     = 3;

  localparam logic [6:0] CtrlMaxLen = 7'd125;
  localparam logic [6:0] LenCode16  = 7'd126;
  localparam logic [6:0] LenCode64  = 7'd127;

  localparam logic [CntW-1:0] Ext16LastCnt = CntW'(1);
  localparam logic [CntW-1:0] Ext64LastCnt = CntW'(7);
  localparam logic [CntW-1:0] KeyLastCnt   = CntW'(3);

  localparam logic [3:0] OpText   = 4'd1;
  localparam logic [3:0] OpBinary = 4'd2;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_LEN7,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_EMPTY    = 2'd1,
    EV_CTRL_ERR = 2'd2
  } event_e;

  typedef struct packed {
    event_e             ev;
    logic [7:0]         data;
    logic               last;
    logic               fin;
    logic [3:0]         opcode;
    logic               rsv1;
    logic               binary;
    logic [PlenW-1:0]   plen;
    logic               bad;
  } result_t;

  function automatic logic opcode_reserved(input logic [3:0] op);
    return ((op >= 4'd3) && (op <= 4'd7)) || (op >= 4'd11);
  endfunction

endpackage

[hdl/wsfp_parser.sv]
// Header/payload parser: frame state registers and per-beat result logic.
module wsfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        byte_i,
  input  logic              chunk_last_i,
  output logic              res_valid_o,
  output wsfp_pkg::result_t res_o
);
  import wsfp_pkg::*;

  phase_e               phase_q, phase_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 ext_long_q, ext_long_d;
  logic                 fin_q, fin_d;
  logic [3:0]           op_q, op_d;
  logic                 mrsv1_q, mrsv1_d;
  logic                 mbin_q, mbin_d;
  logic                 mask_q, mask_d;
  logic [LenBits-1:0]   dec_q, dec_d;
  logic [LenBits-1:0]   rem_q, rem_d;
  logic [1:0]           kidx_q, kidx_d;
  logic                 disc_q, disc_d;
  logic [7:0]           key_q [4];

  logic                 key_we;
  logic                 hdr_done;
  logic                 len_done;
  logic                 frm_done;
  logic [LenBits-1:0]   new_len;
  logic [6:0]           l7;
  logic [7:0]           kbyte;

  assign l7    = byte_i[6:0];
  assign kbyte = mask_q ? key_q[kidx_q] : 8'd0;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    ext_long_d = ext_long_q;
    fin_d      = fin_q;
    op_d       = op_q;
    mrsv1_d    = mrsv1_q;
    mbin_d     = mbin_q;
    mask_d     = mask_q;
    dec_d      = dec_q;
    rem_d      = rem_q;
    kidx_d     = kidx_q;
    disc_d     = disc_q;
    key_we     = 1'b0;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    frm_done   = 1'b0;
    new_len    = dec_q;
    res_valid_o = 1'b0;
    res_o.ev     = EV_DATA;
    res_o.data   = 8'd0;
    res_o.last   = 1'b0;
    res_o.fin    = fin_q;
    res_o.opcode = op_q;
    res_o.rsv1   = mrsv1_q;
    res_o.binary = mbin_q;
    res_o.plen   = '0;
    res_o.bad    = 1'b0;

    if (beat_i) begin
      if (disc_q) begin
        if (chunk_last_i) disc_d = 1'b0;
      end else begin
        unique case (phase_q)
          PH_LEN7: begin
            mask_d = byte_i[7];
            if (op_q[3] && (l7 > CtrlMaxLen)) begin
              res_valid_o = 1'b1;
              res_o.ev    = EV_CTRL_ERR;
              res_o.plen  = PlenW'(l7);
              phase_d     = PH_HEAD;
              fin_d       = 1'b0;
              mask_d      = 1'b0;
              kidx_d      = '0;
              mbin_d      = 1'b0;
              rem_d       = '0;
              op_d        = '0;
              mrsv1_d     = 1'b0;
              dec_d       = '0;
              disc_d      = !chunk_last_i;
            end else if (l7 == LenCode16 || l7 == LenCode64) begin
              dec_d      = '0;
              phase_d    = PH_EXT;
              cnt_d      = '0;
              ext_long_d = (l7 == LenCode64);
            end else begin
              new_len  = LenBits'(l7);
              dec_d    = new_len;
              len_done = 1'b1;
            end
          end
          PH_EXT: begin
            new_len = {dec_q[LenBits-9:0], byte_i};
            dec_d   = new_len;
            if (cnt_q == (ext_long_q ? Ext64LastCnt : Ext16LastCnt)) begin
              len_done = 1'b1;
            end else begin
              cnt_d = cnt_q + CntW'(1);
            end
          end
          PH_KEY: begin
            key_we = 1'b1;
            if (cnt_q == KeyLastCnt) begin
              hdr_done = 1'b1;
            end else begin
              cnt_d = cnt_q + CntW'(1);
            end
          end
          PH_DATA: begin
            kidx_d      = kidx_q + 2'd1;
            rem_d       = rem_q - LenBits'(1);
            res_valid_o = 1'b1;
            res_o.ev    = EV_DATA;
            res_o.data  = byte_i ^ kbyte;
            res_o.last  = (rem_d == '0);
            res_o.plen  = PlenW'(dec_q);
            res_o.bad   = (rem_d == '0) && opcode_reserved(op_q);
            frm_done    = (rem_d == '0);
          end
          default: begin
            fin_d   = byte_i[7];
            op_d    = byte_i[3:0];
            if (byte_i[3:0] == OpText || byte_i[3:0] == OpBinary) begin
              mbin_d  = (byte_i[3:0] == OpBinary);
              mrsv1_d = byte_i[6];
            end
            phase_d = PH_LEN7;
          end
        endcase

        if (len_done) begin
          if (mask_d) begin
            phase_d = PH_KEY;
            cnt_d   = '0;
          end else begin
            hdr_done = 1'b1;
          end
        end

        if (hdr_done) begin
          kidx_d = '0;
          rem_d  = new_len;
          if (new_len != '0) begin
            phase_d = PH_DATA;
          end else begin
            res_valid_o = 1'b1;
            res_o.ev    = EV_EMPTY;
            res_o.last  = 1'b1;
            res_o.bad   = opcode_reserved(op_q);
            frm_done    = 1'b1;
          end
        end

        if (frm_done) begin
          phase_d = PH_HEAD;
          if (fin_q) begin
            fin_d  = 1'b0;
            mask_d = 1'b0;
            kidx_d = '0;
            mbin_d = 1'b0;
            rem_d  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEAD;
      cnt_q      <= '0;
      ext_long_q <= 1'b0;
      fin_q      <= 1'b0;
      op_q       <= '0;
      mrsv1_q    <= 1'b0;
      mbin_q     <= 1'b0;
      mask_q     <= 1'b0;
      dec_q      <= '0;
      rem_q      <= '0;
      kidx_q     <= '0;
      disc_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      ext_long_q <= ext_long_d;
      fin_q      <= fin_d;
      op_q       <= op_d;
      mrsv1_q    <= mrsv1_d;
      mbin_q     <= mbin_d;
      mask_q     <= mask_d;
      dec_q      <= dec_d;
      rem_q      <= rem_d;
      kidx_q     <= kidx_d;
      disc_q     <= disc_d;
    end
  end

  // mask key store, written only during the key bytes of the header
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[cnt_q[1:0]] <= byte_i;
    end
  end

endmodule

[hdl/wsfp_out_reg.sv]
// Result register between the parser and the output stream.
module wsfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  wsfp_pkg::result_t res_i,
  input  logic              take_i,
  output logic              valid_o,
  output wsfp_pkg::result_t res_o
);
  import wsfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[hdl/websocket_frame_parser.sv]
// WebSocket receive deframer: one input byte per beat, at most one result beat.
// Each result is registered and appears on the output in the cycle after its input beat.
// Throughput: one byte per cycle; input stalls only while a result is held
// in the output register and the sink is not ready.
// Reset (rst_ni low, async): parser returns to awaiting a frame header,
// message state cleared, output register empty.
module websocket_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // chunk_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [8] message_final, [12:9] frame_opcode, [13] compressed,
  // [14] is_binary, [78:15] payload_length, [79] bad_opcode
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // frame_last
  output logic [1:0]  m_axis_tuser_o    // [1:0] event_res
);
  import wsfp_pkg::*;

  logic    beat;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    out_valid;

  assign s_axis_tready_o = !out_valid || m_axis_tready_i;
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  wsfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .byte_i       (s_axis_tdata_i),
    .chunk_last_i (s_axis_tlast_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wsfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (beat),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_i      (m_axis_tready_i),
    .valid_o     (out_valid),
    .res_o       (out_res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tlast_o  = out_res.last;
  assign m_axis_tuser_o  = out_res.ev;
  assign m_axis_tdata_o  = {out_res.bad, out_res.plen, out_res.binary, out_res.rsv1,
                            out_res.opcode, out_res.fin, out_res.data};

endmodule
